FILE: src/pfts_pkg.sv
// Shared types, field widths and codes for the priority task scheduler.
package pfts_pkg;

    localparam int TASK_ID_W      = 5;
    localparam int ADDR_W         = 32;
    localparam int PRIO_REQ_W     = 4;

    localparam int NUM_PRIORITIES_DEF = 16;
    localparam int MAX_TASKS_DEF      = 32;
    localparam int RING_LENGTH_DEF    = 32;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SLOT    = 2'd1,
        ST_RING_FULL  = 2'd2,
        ST_NONE_READY = 2'd3
    } status_t;

    localparam logic MODE_ADD      = 1'b0;
    localparam logic MODE_SCHEDULE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT_SCAN,
        S_RING_CHECK,
        S_PRIO_SCAN,
        S_RING_READ,
        S_ENTRY_READ,
        S_RESP
    } sched_state_t;

    typedef struct packed {
        logic                  mode;
        logic [PRIO_REQ_W-1:0] priority_req;
        logic [ADDR_W-1:0]     entry_addr;
    } in_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] task_id;
        logic [ADDR_W-1:0]    task_entry_addr;
        status_t              status;
    } out_t;

endpackage

FILE: src/priority_fifo_task_scheduler_unit.sv
// Strict-priority multilevel FIFO task scheduler: top level.
//
// Each request (add or schedule) is handled by a small sequencer around one
// step-and-compare unit, and s_ready stays low until the result has been
// placed in the output register. An add scans the task slots one per cycle
// circularly from just after the last slot issued, then checks and appends to
// the ring of its priority, or reports no slot when every slot is taken. A
// schedule scans the priority levels one per cycle from the top, then reads
// the ring memory and the entry-address memory in turn, or reports none ready
// when nothing is ready. The result waits while an earlier result still holds
// the output register against m_ready. A new request is taken while the
// previous result still waits on m_ready. No clearing pass is needed after
// reset.
module priority_fifo_task_scheduler_unit #(
    parameter int NUM_PRIORITIES = pfts_pkg::NUM_PRIORITIES_DEF,
    parameter int MAX_TASKS      = pfts_pkg::MAX_TASKS_DEF,
    parameter int RING_LENGTH    = pfts_pkg::RING_LENGTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pfts_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output pfts_pkg::out_t m_payload
);
    import pfts_pkg::*;

    localparam int ID_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int PRIO_W     = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int RING_W     = (RING_LENGTH > 1) ? $clog2(RING_LENGTH) : 1;
    localparam int CNT_W      = $clog2(RING_LENGTH + 1);
    localparam int RING_DEPTH = 1 << (PRIO_W + RING_W);

    sched_state_t state_reg, state_next;

    // Control state
    logic [MAX_TASKS-1:0] used_reg;
    logic [ID_W-1:0]      last_reg;
    logic [RING_W-1:0]    head_reg  [NUM_PRIORITIES];
    logic [RING_W-1:0]    tail_reg  [NUM_PRIORITIES];
    logic [CNT_W-1:0]     count_reg [NUM_PRIORITIES];
    logic                 m_valid_reg;

    // Working registers
    logic [ID_W-1:0]      cand_reg;
    logic [ID_W-1:0]      probe_reg;
    logic [PRIO_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ID_W-1:0]      resp_id_reg;
    status_t              resp_status_reg;
    logic                 resp_use_entry_reg;
    out_t                 m_payload_reg;

    // Memories
    logic [ADDR_W-1:0]    slot_entry_mem [MAX_TASKS];
    logic [ID_W-1:0]      ring_mem [RING_DEPTH];
    logic [ID_W-1:0]      ring_rd_reg;
    logic [ADDR_W-1:0]    entry_rd_reg;

    // Shared step unit and conditions
    logic [PRIO_W-1:0]    prio_sat;
    logic [ID_W-1:0]      cand_step;
    logic [ID_W-1:0]      first_cand;
    logic                 slot_free;
    logic                 ring_empty;
    logic                 ring_full;
    logic                 probes_done;
    logic [RING_W-1:0]    head_step;
    logic [RING_W-1:0]    tail_step;
    logic [RING_W+PRIO_W-1:0] ring_wr_addr;
    logic [RING_W+PRIO_W-1:0] ring_rd_addr;

    // Sequencer controls
    logic accept;
    logic do_claim;
    logic do_pop;
    logic do_entry_read;
    logic load_out;

    always_comb begin
        if (32'(s_payload.priority_req) >= NUM_PRIORITIES) begin
            prio_sat = PRIO_W'(NUM_PRIORITIES - 1);
        end else begin
            prio_sat = PRIO_W'(s_payload.priority_req);
        end
    end

    assign cand_step   = (cand_reg == ID_W'(MAX_TASKS - 1)) ? '0 : cand_reg + 1'b1;
    assign first_cand  = (last_reg == ID_W'(MAX_TASKS - 1)) ? '0 : last_reg + 1'b1;
    assign slot_free   = !used_reg[cand_reg];
    assign probes_done = (probe_reg == ID_W'(MAX_TASKS - 1));
    assign ring_empty  = (count_reg[idx_reg] == '0);
    assign ring_full   = (count_reg[idx_reg] >= CNT_W'(RING_LENGTH));
    assign head_step   = (head_reg[idx_reg] == RING_W'(RING_LENGTH - 1)) ?
                         '0 : head_reg[idx_reg] + 1'b1;
    assign tail_step   = (tail_reg[idx_reg] == RING_W'(RING_LENGTH - 1)) ?
                         '0 : tail_reg[idx_reg] + 1'b1;
    assign ring_wr_addr = {idx_reg, tail_reg[idx_reg]};
    assign ring_rd_addr = {idx_reg, head_reg[idx_reg]};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_payload.mode == MODE_SCHEDULE) ? S_PRIO_SCAN : S_SLOT_SCAN;
                end
            end
            S_SLOT_SCAN: begin
                if (slot_free) begin
                    state_next = S_RING_CHECK;
                end else if (probes_done) begin
                    state_next = S_RESP;
                end
            end
            S_RING_CHECK: begin
                state_next = S_RESP;
            end
            S_PRIO_SCAN: begin
                if (!ring_empty) begin
                    state_next = S_RING_READ;
                end else if (idx_reg == '0) begin
                    state_next = S_RESP;
                end
            end
            S_RING_READ: begin
                state_next = S_ENTRY_READ;
            end
            S_ENTRY_READ: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        accept        = 1'b0;
        do_claim      = 1'b0;
        do_pop        = 1'b0;
        do_entry_read = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            S_IDLE:       accept        = s_valid;
            S_RING_CHECK: do_claim      = !ring_full;
            S_RING_READ:  do_pop        = 1'b1;
            S_ENTRY_READ: do_entry_read = 1'b1;
            S_RESP:       load_out      = !m_valid_reg || m_ready;
            default: begin
                accept = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            last_reg    <= ID_W'(MAX_TASKS - 1);
            m_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PRIORITIES; p++) begin
                head_reg[p]  <= '0;
                tail_reg[p]  <= '0;
                count_reg[p] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (do_claim) begin
                used_reg[cand_reg] <= 1'b1;
                last_reg           <= cand_reg;
                tail_reg[idx_reg]  <= tail_step;
                count_reg[idx_reg] <= count_reg[idx_reg] + 1'b1;
            end
            if (do_pop) begin
                head_reg[idx_reg]  <= head_step;
                count_reg[idx_reg] <= count_reg[idx_reg] - 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath and result assembly
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    addr_reg           <= s_payload.entry_addr;
                    cand_reg           <= first_cand;
                    probe_reg          <= '0;
                    resp_use_entry_reg <= 1'b0;
                    idx_reg <= (s_payload.mode == MODE_SCHEDULE) ?
                               PRIO_W'(NUM_PRIORITIES - 1) : prio_sat;
                end
            end
            S_SLOT_SCAN: begin
                if (!slot_free) begin
                    cand_reg        <= cand_step;
                    probe_reg       <= probe_reg + 1'b1;
                    resp_id_reg     <= '0;
                    resp_status_reg <= ST_NO_SLOT;
                end
            end
            S_RING_CHECK: begin
                if (ring_full) begin
                    resp_id_reg     <= '0;
                    resp_status_reg <= ST_RING_FULL;
                end else begin
                    resp_id_reg     <= cand_reg;
                    resp_status_reg <= ST_OK;
                end
            end
            S_PRIO_SCAN: begin
                if (ring_empty) begin
                    idx_reg         <= idx_reg - 1'b1;
                    resp_id_reg     <= '0;
                    resp_status_reg <= ST_NONE_READY;
                end
            end
            S_ENTRY_READ: begin
                resp_id_reg        <= ring_rd_reg;
                resp_status_reg    <= ST_OK;
                resp_use_entry_reg <= 1'b1;
            end
            S_RESP: begin
                if (load_out) begin
                    m_payload_reg.task_id         <= TASK_ID_W'(resp_id_reg);
                    m_payload_reg.task_entry_addr <= resp_use_entry_reg ? entry_rd_reg : '0;
                    m_payload_reg.status          <= resp_status_reg;
                end
            end
            default: begin
                resp_use_entry_reg <= 1'b0;
            end
        endcase
    end

    // Slot entry memory
    always_ff @(posedge aclk) begin
        if (do_claim) begin
            slot_entry_mem[cand_reg] <= addr_reg;
        end
        if (do_entry_read) begin
            entry_rd_reg <= slot_entry_mem[ring_rd_reg];
        end
    end

    // Ready ring memory, one region per priority level
    always_ff @(posedge aclk) begin
        if (do_claim) begin
            ring_mem[ring_wr_addr] <= cand_reg;
        end
        if (do_pop) begin
            ring_rd_reg <= ring_mem[ring_rd_addr];
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while sequencer busy");

    a_resp_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && (!m_valid || m_ready)) |=> (m_valid && s_ready))
        else $error("result not delivered to output register");

    // The level index is only meaningful once a request has been taken
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (count_reg[idx_reg] <= CNT_W'(RING_LENGTH)))
        else $error("ring count beyond ring length");

    a_claim_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        do_claim |-> !used_reg[cand_reg])
        else $error("claimed slot already in use");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> !ring_empty)
        else $error("pop from an empty ring");

endmodule
